// File: hdl/rsvm_pkg.sv
`default_nettype none
package rsvm_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PC_W       = 17;
  localparam int unsigned PLEN_W     = 17;
  localparam int unsigned REG_FIELD_W = 8;
  localparam int unsigned APB_ADDR_W = 3;

  localparam int unsigned MEMORY_DEPTH_DEF   = 4096;
  localparam int unsigned REGISTER_COUNT_DEF = 16;
  localparam int unsigned STACK_DEPTH_DEF    = 64;
  localparam int unsigned PROGRAM_DEPTH_DEF  = 65536;

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_START = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    OP_HALT  = 5'd0,
    OP_LOAD  = 5'd1,
    OP_MOVE  = 5'd2,
    OP_ADD   = 5'd3,
    OP_SUB   = 5'd4,
    OP_MUL   = 5'd5,
    OP_DIV   = 5'd6,
    OP_AND   = 5'd7,
    OP_OR    = 5'd8,
    OP_JMP   = 5'd9,
    OP_JZ    = 5'd10,
    OP_JNZ   = 5'd11,
    OP_PUSH  = 5'd12,
    OP_POP   = 5'd13,
    OP_CALL  = 5'd14,
    OP_RET   = 5'd15,
    OP_MEMLD = 5'd16,
    OP_MEMST = 5'd17,
    OP_PRINT = 5'd18
  } op_e;

  typedef struct packed {
    logic [1:0]               command;
    logic [4:0]               opcode;
    logic [REG_FIELD_W-1:0]   dest_reg;
    logic [REG_FIELD_W-1:0]   src_reg;
    logic signed [DATA_W-1:0] immediate;
    logic signed [DATA_W-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]              next_pc;
    logic                     running;
    logic                     print_valid;
    logic signed [DATA_W-1:0] print_value;
    logic signed [DATA_W-1:0] read_value;
    logic                     stack_overflow;
  } out_item_t;

  // Jump targets that are negative or beyond the program space saturate.
  function automatic logic [PC_W-1:0] clamp_target(input logic [DATA_W-1:0] t,
                                                   input logic [PC_W-1:0] depth);
    logic [PC_W-1:0] r;
    if (t[DATA_W-1] || (t > {{(DATA_W-PC_W){1'b0}}, depth})) begin
      r = depth;
    end else begin
      r = t[PC_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/rsvm_ram.sv
`default_nettype none
module rsvm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: hdl/rsvm_div.sv
`default_nettype none
module rsvm_div import rsvm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [DATA_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, done_q, neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q, quo_q, dvs_q;
  logic [DATA_W:0]   shifted;
  logic              fits;

  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DATA_W-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      quo_q <= dividend_i[DATA_W-1] ? (DATA_W'(0) - dividend_i) : dividend_i;
      dvs_q <= divisor_i[DATA_W-1] ? (DATA_W'(0) - divisor_i) : divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DATA_W'(shifted - {1'b0, dvs_q});
      end else begin
        rem_q <= shifted[DATA_W-1:0];
      end
      quo_q <= {quo_q[DATA_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule
`default_nettype wire

// File: hdl/register_stack_vm_core_unit.sv
`default_nettype none
// Register/stack virtual machine core. Each input beat carries one host
// command or one instruction fetched at the reported pc, and produces exactly
// one output beat with the new pc, the running flag, any print value, any host
// read value and the stack overflow flag. The program length is written over
// the APB port at address 0; the user must write it only while the core is
// idle, as the block itself does not enforce this. After reset the core sweeps
// the data memory to zero, one word per cycle, and holds in_stall_o high
// meanwhile. After that each accepted input beat goes through two register
// file reads on the single read port (ST_RD1, ST_RD2), the execute state
// ST_EXEC and the hand-off state ST_FIN, which registers the output beat and
// waits there while the receiver still stalls the previous output beat. Pop,
// ret and memld add ST_MEMRD for the registered memory read, and div adds
// ST_DIV for the bit-serial divider. A new beat is accepted once the sequencer
// is back in idle, even while the previous result waits to be taken.
module register_stack_vm_core_unit import rsvm_pkg::*; #(
  parameter int unsigned MEMORY_DEPTH   = MEMORY_DEPTH_DEF,
  parameter int unsigned REGISTER_COUNT = REGISTER_COUNT_DEF,
  parameter int unsigned STACK_DEPTH    = STACK_DEPTH_DEF,
  parameter int unsigned PROGRAM_DEPTH  = PROGRAM_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int unsigned RAW = $clog2(REGISTER_COUNT);
  localparam int unsigned MAW = $clog2(MEMORY_DEPTH);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
  localparam logic [PC_W-1:0] PDEPTH = PC_W'(PROGRAM_DEPTH);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD1, ST_RD2, ST_EXEC, ST_DIV, ST_MEMRD, ST_FIN
  } state_e;

  typedef enum logic [1:0] {MRD_POP, MRD_MEMLD, MRD_RET} mrd_e;

  state_e state_q;
  mrd_e   mrd_q;

  in_item_t            item_q;
  logic [DATA_W-1:0]   d_q, pv_q, rv_q;
  logic                pvalid_q, ovf_q, rd_vld_q;
  logic [PC_W-1:0]     pc_q;
  logic                active_q;
  logic [PLEN_W-1:0]   len_q;
  logic [SCW-1:0]      stk_cnt_q;
  logic [REGISTER_COUNT-1:0] rf_vld_q;
  logic [MAW-1:0]      clr_q;
  out_item_t           out_q;
  logic                out_valid_q;

  // Configuration port.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : {{(DATA_W-PLEN_W){1'b0}}, len_q};

  // Decoded fields.
  logic            ok1, ok2, both, memok, run;
  logic [RAW-1:0]  r1_idx, r2_idx;
  logic [PC_W-1:0] eff_len, pc_inc, tgt;
  logic [DATA_W-1:0] rf_val, d_val, s_val;

  assign ok1    = item_q.dest_reg < REG_FIELD_W'(REGISTER_COUNT);
  assign ok2    = item_q.src_reg  < REG_FIELD_W'(REGISTER_COUNT);
  assign both   = ok1 && ok2;
  assign r1_idx = item_q.dest_reg[RAW-1:0];
  assign r2_idx = item_q.src_reg[RAW-1:0];
  assign memok  = !item_q.immediate[DATA_W-1] &&
                  (item_q.immediate < DATA_W'(MEMORY_DEPTH));
  assign eff_len = (len_q < PLEN_W'(PROGRAM_DEPTH)) ? len_q : PDEPTH;
  assign run    = active_q && (pc_q < eff_len);
  assign pc_inc = pc_q + 1'b1;
  assign tgt    = clamp_target(item_q.immediate, PDEPTH);

  // Register file: one read and one write port, cleared entries read as zero.
  logic              rf_we;
  logic [DATA_W-1:0] rf_wdata, rf_rdata;
  logic [RAW-1:0]    rf_raddr;

  assign rf_raddr = (state_q == ST_RD1) ? r1_idx : r2_idx;
  assign rf_val   = rd_vld_q ? rf_rdata : '0;
  assign d_val    = ok1 ? d_q : '0;
  assign s_val    = ok2 ? rf_val : '0;

  rsvm_ram #(.WIDTH(DATA_W), .DEPTH(REGISTER_COUNT)) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (r1_idx),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  // Data memory, swept to zero after reset.
  logic              dm_we;
  logic [MAW-1:0]    dm_waddr;
  logic [DATA_W-1:0] dm_wdata, dm_rdata;

  rsvm_ram #(.WIDTH(DATA_W), .DEPTH(MEMORY_DEPTH)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .raddr_i (item_q.immediate[MAW-1:0]),
    .rdata_o (dm_rdata)
  );

  // Stack store.
  logic              st_we;
  logic [DATA_W-1:0] st_wdata, st_rdata;
  logic [SCW-1:0]    stk_dec;

  assign stk_dec = stk_cnt_q - 1'b1;

  rsvm_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (stk_cnt_q[SAW-1:0]),
    .wdata_i (st_wdata),
    .raddr_i (stk_dec[SAW-1:0]),
    .rdata_o (st_rdata)
  );

  // Divider, used by div.
  logic              div_start, div_busy, div_done;
  logic [DATA_W-1:0] div_quo;

  rsvm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (d_val),
    .divisor_i  (s_val),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Execute-cycle decisions.
  logic              x_we, x_active, x_pvalid, x_ovf, x_push, x_dec, x_mst, x_div;
  logic [DATA_W-1:0] x_wdata, x_pv, x_rv, x_push_data;
  logic [PC_W-1:0]   x_pc;
  logic              x_mrd;
  mrd_e              x_kind;
  logic              stk_full, stk_empty;
  logic [DATA_W-1:0] product;

  assign stk_full  = stk_cnt_q >= SCW'(STACK_DEPTH);
  assign stk_empty = stk_cnt_q == '0;
  assign product   = DATA_W'(d_val * s_val);

  always_comb begin
    x_we = 1'b0;  x_wdata = '0;  x_pc = pc_q;  x_active = active_q;
    x_pvalid = 1'b0;  x_pv = '0;  x_rv = '0;  x_ovf = 1'b0;
    x_push = 1'b0;  x_push_data = '0;  x_dec = 1'b0;  x_mst = 1'b0;
    x_div = 1'b0;  x_mrd = 1'b0;  x_kind = MRD_POP;
    case (item_q.command)
      CMD_START: begin
        x_pc = '0;
        x_active = 1'b1;
      end
      CMD_WRITE: begin
        x_we = ok1;
        x_wdata = item_q.write_value;
      end
      CMD_READ: begin
        x_rv = d_val;
      end
      default: begin
        if (run) begin
          x_pc = pc_inc;
          case (item_q.opcode)
            OP_HALT:  x_active = 1'b0;
            OP_LOAD:  begin x_we = ok1;  x_wdata = item_q.immediate; end
            OP_MOVE:  begin x_we = both; x_wdata = s_val; end
            OP_ADD:   begin x_we = both; x_wdata = d_val + s_val; end
            OP_SUB:   begin x_we = both; x_wdata = d_val - s_val; end
            OP_MUL:   begin x_we = both; x_wdata = product; end
            OP_DIV:   x_div = both && (s_val != '0);
            OP_AND:   begin x_we = both; x_wdata = d_val & s_val; end
            OP_OR:    begin x_we = both; x_wdata = d_val | s_val; end
            OP_JMP:   x_pc = tgt;
            OP_JZ:    if (ok1 && d_val == '0) x_pc = tgt;
            OP_JNZ:   if (ok1 && d_val != '0) x_pc = tgt;
            OP_PUSH: begin
              if (ok1) begin
                x_push = !stk_full;
                x_ovf = stk_full;
                x_push_data = d_val;
              end
            end
            OP_POP: begin
              if (ok1 && !stk_empty) begin
                x_dec = 1'b1;
                x_mrd = 1'b1;
                x_kind = MRD_POP;
              end
            end
            OP_CALL: begin
              x_push = !stk_full;
              x_ovf = stk_full;
              x_push_data = {{(DATA_W-PC_W){1'b0}}, pc_inc};
              x_pc = tgt;
            end
            OP_RET: begin
              if (!stk_empty) begin
                x_dec = 1'b1;
                x_mrd = 1'b1;
                x_kind = MRD_RET;
              end
            end
            OP_MEMLD: begin
              if (ok1 && memok) begin
                x_mrd = 1'b1;
                x_kind = MRD_MEMLD;
              end
            end
            OP_MEMST: x_mst = ok1 && memok;
            OP_PRINT: begin
              x_pvalid = ok1;
              x_pv = d_val;
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  // Memory write ports by sequencer state.
  always_comb begin
    rf_we = 1'b0;
    rf_wdata = x_wdata;
    case (state_q)
      ST_EXEC: rf_we = x_we;
      ST_DIV: begin
        rf_we = div_done;
        rf_wdata = div_quo;
      end
      ST_MEMRD: begin
        rf_we = (mrd_q != MRD_RET);
        rf_wdata = (mrd_q == MRD_MEMLD) ? dm_rdata : st_rdata;
      end
      default: ;
    endcase
  end

  assign dm_we     = (state_q == ST_CLEAR) || ((state_q == ST_EXEC) && x_mst);
  assign dm_waddr  = (state_q == ST_CLEAR) ? clr_q : item_q.immediate[MAW-1:0];
  assign dm_wdata  = (state_q == ST_CLEAR) ? '0 : d_val;
  assign st_we     = (state_q == ST_EXEC) && x_push;
  assign st_wdata  = x_push_data;
  assign div_start = (state_q == ST_EXEC) && x_div;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      mrd_q       <= MRD_POP;
      clr_q       <= '0;
      pc_q        <= '0;
      active_q    <= 1'b0;
      len_q       <= '0;
      stk_cnt_q   <= '0;
      rf_vld_q    <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        len_q <= pwdata[PLEN_W-1:0];
      end
      if (rf_we) begin
        rf_vld_q[r1_idx] <= 1'b1;
      end
      // In the hand-off state the output register is managed below.
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == MAW'(MEMORY_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= ST_RD1;
          end
        end
        ST_RD1: begin
          rd_vld_q <= rf_vld_q[rf_raddr];
          state_q  <= ST_RD2;
        end
        ST_RD2: begin
          d_q      <= rf_val;
          rd_vld_q <= rf_vld_q[rf_raddr];
          state_q  <= ST_EXEC;
        end
        ST_EXEC: begin
          pc_q     <= x_pc;
          active_q <= x_active;
          pvalid_q <= x_pvalid;
          pv_q     <= x_pv;
          rv_q     <= x_rv;
          ovf_q    <= x_ovf;
          mrd_q    <= x_kind;
          if (x_push) begin
            stk_cnt_q <= stk_cnt_q + 1'b1;
          end else if (x_dec) begin
            stk_cnt_q <= stk_dec;
          end
          if (x_div) begin
            state_q <= ST_DIV;
          end else if (x_mrd) begin
            state_q <= ST_MEMRD;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_MEMRD: begin
          if (mrd_q == MRD_RET) begin
            pc_q <= clamp_target(st_rdata, PDEPTH);
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.next_pc        <= pc_q[15:0];
            out_q.running        <= run;
            out_q.print_valid    <= pvalid_q;
            out_q.print_value    <= pv_q;
            out_q.read_value     <= rv_q;
            out_q.stack_overflow <= ovf_q;
            out_valid_q          <= 1'b1;
            state_q              <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The stack count never passes the stack depth.
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_cnt_q <= SCW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // The program counter never passes the saturation value.
  a_pc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PDEPTH)
    else $error("pc beyond program depth");

  // An accepted beat closes the input until its result is produced.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while busy");

  // The divider only runs while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV))
    else $error("divider busy outside divide wait");

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps

// Scoreboard for the VM core. It keeps its own copy of the machine state,
// works out the result beat for each accepted input beat, and compares the
// output beats against those expectations in order.
class vm_scoreboard;
  logic [31:0] regs[16];
  logic [31:0] dmem[4096];
  logic [31:0] stk[64];
  int unsigned depth_used;
  logic [16:0] pc;
  bit          active;
  logic [16:0] plen;
  rsvm_pkg::out_item_t pending[$];
  int unsigned errors;

  function void clear();
    foreach (regs[i]) regs[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    foreach (stk[i]) stk[i] = '0;
    depth_used = 0;
    pc = '0;
    active = 0;
    plen = '0;
    pending.delete();
    errors = 0;
  endfunction

  function logic [16:0] saturate_target(logic [31:0] t);
    if (t[31] || t > 32'd65536) return 17'd65536;
    return t[16:0];
  endfunction

  // The length never counts beyond the program space.
  function bit in_program();
    logic [16:0] eff;
    eff = (plen > 17'd65536) ? 17'd65536 : plen;
    return active && (pc < eff);
  endfunction

  // Works out the result of one accepted beat and queues it.
  function void note_beat(rsvm_pkg::in_item_t b);
    rsvm_pkg::out_item_t r;
    bit ok1, ok2, memok;
    logic [31:0] s, d, q, ma, mb;
    r = '0;
    ok1 = b.dest_reg < 16;
    ok2 = b.src_reg < 16;
    memok = !b.immediate[31] && b.immediate < 4096;
    case (rsvm_pkg::cmd_e'(b.command))
      rsvm_pkg::CMD_START: begin
        pc = '0;
        active = 1;
      end
      rsvm_pkg::CMD_WRITE: if (ok1) regs[b.dest_reg[3:0]] = b.write_value;
      rsvm_pkg::CMD_READ: if (ok1) r.read_value = regs[b.dest_reg[3:0]];
      default: if (in_program()) begin
        s = ok2 ? regs[b.src_reg[3:0]] : '0;
        d = ok1 ? regs[b.dest_reg[3:0]] : '0;
        pc = pc + 1;
        case (b.opcode)
          rsvm_pkg::OP_HALT: active = 0;
          rsvm_pkg::OP_LOAD: if (ok1) d = b.immediate;
          rsvm_pkg::OP_MOVE: if (ok1 && ok2) d = s;
          rsvm_pkg::OP_ADD: if (ok1 && ok2) d = d + s;
          rsvm_pkg::OP_SUB: if (ok1 && ok2) d = d - s;
          rsvm_pkg::OP_MUL: if (ok1 && ok2) d = d * s;
          rsvm_pkg::OP_DIV: if (ok1 && ok2 && s != 0) begin
            // Truncating signed division on magnitudes; the minimum over -1
            // wraps back to the minimum.
            ma = d[31] ? -d : d;
            mb = s[31] ? -s : s;
            q = ma / mb;
            d = (d[31] != s[31]) ? -q : q;
          end
          rsvm_pkg::OP_AND: if (ok1 && ok2) d = d & s;
          rsvm_pkg::OP_OR: if (ok1 && ok2) d = d | s;
          rsvm_pkg::OP_JMP: pc = saturate_target(b.immediate);
          rsvm_pkg::OP_JZ: if (ok1 && d == 0) pc = saturate_target(b.immediate);
          rsvm_pkg::OP_JNZ: if (ok1 && d != 0) pc = saturate_target(b.immediate);
          rsvm_pkg::OP_PUSH: if (ok1) begin
            if (depth_used < 64) stk[depth_used++] = d;
            else r.stack_overflow = 1;
          end
          rsvm_pkg::OP_POP: if (ok1 && depth_used > 0) d = stk[--depth_used];
          rsvm_pkg::OP_CALL: begin
            if (depth_used < 64) stk[depth_used++] = {15'd0, pc};
            else r.stack_overflow = 1;
            pc = saturate_target(b.immediate);
          end
          rsvm_pkg::OP_RET: if (depth_used > 0) pc = saturate_target(stk[--depth_used]);
          rsvm_pkg::OP_MEMLD: if (ok1 && memok) d = dmem[b.immediate[11:0]];
          rsvm_pkg::OP_MEMST: if (ok1 && memok) dmem[b.immediate[11:0]] = d;
          rsvm_pkg::OP_PRINT: if (ok1) begin
            r.print_valid = 1;
            r.print_value = d;
          end
          default: ;
        endcase
        if (ok1) regs[b.dest_reg[3:0]] = d;
      end
    endcase
    r.next_pc = pc[15:0];
    r.running = in_program();
    pending.push_back(r);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  task check_beat(rsvm_pkg::out_item_t g);
    rsvm_pkg::out_item_t e;
    if (pending.size() == 0) begin
      report("unexpected beat", g.next_pc, 0);
      return;
    end
    e = pending.pop_front();
    if (g.next_pc !== e.next_pc) report("next_pc", g.next_pc, e.next_pc);
    if (g.running !== e.running) report("running", g.running, e.running);
    if (g.print_valid !== e.print_valid) report("print_valid", g.print_valid, e.print_valid);
    if (g.print_value !== e.print_value) report("print_value", g.print_value, e.print_value);
    if (g.read_value !== e.read_value) report("read_value", g.read_value, e.read_value);
    if (g.stack_overflow !== e.stack_overflow)
      report("stack_overflow", g.stack_overflow, e.stack_overflow);
  endtask
endclass

module testbench;
  import rsvm_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;
  logic      psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  localparam logic [APB_ADDR_W-1:0] ADDR_PROGRAM_LENGTH = '0;

  vm_scoreboard board;
  // Idle percentages for the sender and the receiver, changed per phase.
  int unsigned send_idle_pct, recv_idle_pct;
  // While set, the receiver stalls for a long stretch to back the core up.
  bit hold_receiver;

  register_stack_vm_core_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // Generous limit: the clearing sweep, then roughly a thousand beats with
  // divides, stalls and gaps stay far below this.
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  // Receiver: stalls at random, or for a long stretch when asked. Every
  // accepted beat goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_beat(out_data_o);
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= hold_receiver || ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    int unsigned n;
    hold_receiver = 0;
    forever begin
      @(posedge clk_i);
      if (hold_receiver) begin
        for (n = 0; n < 200; n++) @(posedge clk_i);
        hold_receiver = 0;
      end
    end
  end

  // Sends one beat, idling at random beforehand, and waits until accepted.
  // Valid stays high after acceptance until the next call or a drain.
  task automatic send_beat(in_item_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_beat(b);
  endtask

  task automatic drain();
    int unsigned n;
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    for (n = 0; n < 60; n++) @(posedge clk_i);
  endtask

  // APB write of the program length, setup then access phase, only while the core is idle.
  task automatic write_length(logic [16:0] len);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_PROGRAM_LENGTH;
    pwdata <= {15'd0, len};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.plen = len;
  endtask

  function automatic in_item_t make_beat(cmd_e c, op_e o, logic [7:0] d, logic [7:0] s,
                                         logic [31:0] imm, logic [31:0] wv);
    in_item_t b;
    b.command = c;
    b.opcode = o;
    b.dest_reg = d;
    b.src_reg = s;
    b.immediate = imm;
    b.write_value = wv;
    return b;
  endfunction

  // Mostly valid registers and in-range targets so programs actually run,
  // with occasional out-of-range indexes, wild immediates and host commands.
  function automatic in_item_t random_beat(int unsigned plen);
    in_item_t b;
    int unsigned pick;
    b = in_item_t'(($bits(in_item_t))'({$urandom, $urandom, $urandom}));
    pick = $urandom_range(99);
    if (pick < 4) b.command = CMD_START;
    else if (pick < 12) b.command = CMD_WRITE;
    else if (pick < 18) b.command = CMD_READ;
    else b.command = CMD_EXEC;
    if ($urandom_range(9) != 0) b.opcode = op_e'($urandom_range(18));
    // Halt would stop most programs early; keep it rare.
    if (b.opcode == OP_HALT && $urandom_range(3) != 0) b.opcode = OP_ADD;
    if ($urandom_range(9) != 0) b.dest_reg = 8'($urandom_range(15));
    if ($urandom_range(9) != 0) b.src_reg = 8'($urandom_range(15));
    pick = $urandom_range(9);
    if (pick < 5) b.immediate = $urandom_range(plen == 0 ? 0 : plen - 1);
    else if (pick < 8) b.immediate = $urandom_range(4095);
    else if (pick < 9) b.immediate = $urandom_range(15) - 8;
    if ($urandom_range(3) == 0) b.write_value = $urandom_range(7) - 3;
    return b;
  endfunction

  initial begin
    int unsigned i, k, phase;
    logic [16:0] lens[4];
    board = new();
    board.clear();
    send_idle_pct = 32;
    recv_idle_pct = 75;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: length zero first, so executes do nothing.
    send_beat(make_beat(CMD_EXEC, OP_LOAD, 8'd1, 8'd0, 32'd5, 32'd0));
    drain();
    write_length(17'd65536);
    send_beat(make_beat(CMD_START, OP_HALT, 8'd0, 8'd0, 32'd0, 32'd0));
    send_beat(make_beat(CMD_WRITE, OP_HALT, 8'd1, 8'd0, 32'd0, 32'h8000_0000));
    send_beat(make_beat(CMD_WRITE, OP_HALT, 8'd2, 8'd0, 32'd0, 32'hFFFF_FFFF));
    send_beat(make_beat(CMD_WRITE, OP_HALT, 8'd255, 8'd0, 32'd0, 32'h7FFF_FFFF));
    send_beat(make_beat(CMD_READ, OP_HALT, 8'd255, 8'd0, 32'd0, 32'd0));
    // Minimum over minus one, then division by zero.
    send_beat(make_beat(CMD_EXEC, OP_DIV, 8'd1, 8'd2, 32'd0, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_DIV, 8'd1, 8'd3, 32'd0, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_MUL, 8'd2, 8'd1, 32'd0, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_ADD, 8'd16, 8'd1, 32'd0, 32'd0));
    send_beat(make_beat(CMD_EXEC, op_e'(5'd31), 8'd1, 8'd1, 32'd0, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_MEMST, 8'd1, 8'd0, 32'd4095, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_MEMLD, 8'd4, 8'd0, 32'd4095, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_MEMLD, 8'd4, 8'd0, 32'd4096, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_MEMST, 8'd4, 8'd0, 32'hFFFF_FFFF, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_PRINT, 8'd4, 8'd0, 32'd0, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_POP, 8'd5, 8'd0, 32'd0, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_RET, 8'd0, 8'd0, 32'd0, 32'd0));
    // Fill the stack past full with pushes and a call.
    for (i = 0; i < 65; i++)
      send_beat(make_beat(CMD_EXEC, OP_PUSH, 8'd1, 8'd0, 32'd0, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_CALL, 8'd0, 8'd0, 32'd70, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_JZ, 8'd0, 8'd0, 32'd3, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_JNZ, 8'd1, 8'd0, 32'd10, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_JMP, 8'd0, 8'd0, 32'h8000_0000, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_MOVE, 8'd1, 8'd2, 32'd0, 32'd0));
    send_beat(make_beat(CMD_START, OP_HALT, 8'd0, 8'd0, 32'd0, 32'd0));
    send_beat(make_beat(CMD_EXEC, OP_HALT, 8'd0, 8'd0, 32'd0, 32'd0));
    drain();

    // Random part over several program lengths and idling patterns.
    lens = '{17'd1, 17'd200, 17'd65535, 17'd40};
    for (phase = 0; phase < 4; phase++) begin
      write_length(lens[phase]);
      send_idle_pct = (phase == 1) ? 75 : (phase >= 2 ? 0 : 32);
      recv_idle_pct = (phase == 1) ? 32 : (phase >= 2 ? 0 : 75);
      send_beat(make_beat(CMD_START, OP_HALT, 8'd0, 8'd0, 32'd0, 32'd0));
      for (k = 0; k < 215; k++) begin
        if (phase == 2 && k == 20) hold_receiver = 1;
        send_beat(random_beat(lens[phase]));
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
